// ===== sv/assert_macros.svh =====
// assert_macros.svh: concurrent assertion macros for the allocation table block.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define FCA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("fat_chain_allocator: assertion failed");

// Clocked check that also holds while reset is asserted.
`define FCA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("fat_chain_allocator: assertion failed");

`endif

// ===== sv/fca_pkg.sv =====
// fca_pkg: types, widths and codes shared by the allocation table block.
// No dependencies; imported by every module of the block.
package fca_pkg;

  localparam int unsigned FCA_TABLE_DEPTH = 4096;
  localparam int unsigned BLOCK_W         = 12;
  localparam int unsigned COUNT_W         = 13;
  localparam int unsigned TOTAL_W         = 13;
  localparam int unsigned TBLK_W          = 7;
  localparam int unsigned CFG_DATA_W      = 13;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;
  localparam logic [TBLK_W-1:0]  TBLK_RESET  = 7'd4;

  localparam logic [BLOCK_W-1:0] ENTRY_FREE = 12'd0;
  localparam logic [BLOCK_W-1:0] ENTRY_END  = 12'd1;
  localparam logic [2:0]         META_FIXED = 3'd2;

  localparam logic [1:0] MODE_FORMAT   = 2'd0;
  localparam logic [1:0] MODE_ALLOCATE = 2'd1;
  localparam logic [1:0] MODE_FREE     = 2'd2;
  localparam logic [1:0] MODE_SEEK     = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_FREE   = 2'd1;
  localparam logic [1:0] STAT_CHAIN_END = 2'd2;
  localparam logic [1:0] STAT_BOUND     = 2'd3;

  localparam logic CFG_TOTAL_BLOCKS = 1'b0;
  localparam logic CFG_TABLE_BLOCKS = 1'b1;

  typedef struct packed {
    logic [1:0]         mode;
    logic [BLOCK_W-1:0] start_block;
    logic               link_after;
    logic [BLOCK_W-1:0] walk_count;
  } fca_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [BLOCK_W-1:0] result_block;
    logic [COUNT_W-1:0] freed_count;
  } fca_out_t;

  typedef struct packed {
    logic ge_lim;
    logic inc_ge_lim;
    logic is_end;
  } fca_flags_t;

endpackage

// ===== sv/fca_table_ram.sv =====
// fca_table_ram: the allocation table storage, one write and one read port.
// Uses fca_pkg for the default depth and entry width; read data is registered.
module fca_table_ram import fca_pkg::*; #(
  parameter int unsigned DEPTH = FCA_TABLE_DEPTH,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned EW    = BLOCK_W
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [EW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [EW-1:0] rdata_o
);

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/fca_step_unit.sv =====
// fca_step_unit: shared compare and increment unit used by the sequencer steps.
// Depends on fca_pkg for the flag struct and the end-of-chain code.
module fca_step_unit import fca_pkg::*; #(
  parameter int unsigned CW = COUNT_W
) (
  input  logic [CW-1:0] x_i,
  input  logic [CW-1:0] lim_i,
  output logic [CW-1:0] inc_o,
  output fca_flags_t    flags_o
);

  logic [CW-1:0] inc;

  assign inc                = x_i + CW'(1);
  assign inc_o              = inc;
  assign flags_o.ge_lim     = (x_i >= lim_i);
  assign flags_o.inc_ge_lim = (inc >= lim_i);
  assign flags_o.is_end     = (x_i == CW'(ENTRY_END));

endmodule

// ===== sv/fat_chain_allocator.sv =====
// fat_chain_allocator: block allocation table with format, allocate, free chain and seek.
// Depends on fca_pkg, fca_step_unit, fca_table_ram and assert_macros.svh.
//
// Usage. Commands arrive as beats on the in channel (valid/ready) and each command
// produces exactly one beat on the out channel (valid/ready). Two configuration
// registers (total_blocks, table_blocks) are written through the cfg port at any
// time the block is idle; writes complete in the cycle the enable is high.
// The table is a single memory with one write and one registered read port, and a
// small sequencer drives one shared compare/increment unit. Every table read puts
// out an address and then uses the registered data. Format writes one entry per
// cycle across the whole table, allocate scans entries from the first data block,
// free releases the chain link by link and seek follows it link by link.
// One command is worked on at a time; in_ready_o is high only while the sequencer
// waits for a command. A finished result sits in an output register, so a new
// command is taken while the previous result still waits for the receiver. If the
// receiver stalls, the next result is held in the sequencer until the register frees.
// After reset the table is cleared by a pass over every entry; in_ready_o stays
// low during that pass, while configuration writes are taken as usual.
`include "assert_macros.svh"

module fat_chain_allocator import fca_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = FCA_TABLE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  fca_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output fca_out_t              out_data_o
);

  // Address width, stored entry width and counter width all follow the depth.
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned EW = (AW > BLOCK_W) ? AW : BLOCK_W;
  localparam int unsigned CW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_SWEEP    = 10'b00_0000_0010,
    ST_SCAN_RD  = 10'b00_0000_0100,
    ST_SCAN_CHK = 10'b00_0000_1000,
    ST_LINK     = 10'b00_0001_0000,
    ST_FREE_RD  = 10'b00_0010_0000,
    ST_FREE_WR  = 10'b00_0100_0000,
    ST_SEEK_RD  = 10'b00_1000_0000,
    ST_SEEK_NX  = 10'b01_0000_0000,
    ST_FINISH   = 10'b10_0000_0000
  } fca_state_e;

  // Configuration registers.
  logic [TOTAL_W-1:0] total_q;
  logic [TBLK_W-1:0]  tblk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_RESET;
      tblk_q  <= TBLK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TOTAL_BLOCKS: total_q <= cfg_wdata_i[TOTAL_W-1:0];
        CFG_TABLE_BLOCKS: tblk_q  <= cfg_wdata_i[TBLK_W-1:0];
        default: ;
      endcase
    end
  end

  // The usable range ends at the smaller of the configured size and the depth.
  // The first data block follows superblock, directory and the table blocks.
  logic [CW-1:0] lim;
  logic [CW-1:0] meta_end;

  assign lim      = (CW'(total_q) < CW'(TABLE_DEPTH)) ? CW'(total_q) : CW'(TABLE_DEPTH);
  assign meta_end = CW'(tblk_q) + CW'(META_FIXED);

  // Sequencer state. cnt_q is the sweep address, scan index, release count or
  // link count depending on the command; blk_q is the current chain block.
  fca_state_e    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [EW-1:0] blk_q, blk_d;
  logic          bound_q, bound_d;
  logic          mark_q, mark_d;
  fca_in_t       req_q, req_d;
  fca_out_t      res_q, res_d;
  fca_out_t      out_q, out_d;
  logic          out_valid_q, out_valid_d;

  // Shared unit and table ports.
  logic [CW-1:0] unit_x;
  logic [CW-1:0] unit_inc;
  fca_flags_t    fl;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  always_comb begin
    case (state_q)
      ST_FREE_RD, ST_SEEK_RD: unit_x = CW'(blk_q);
      ST_LINK:                unit_x = CW'(req_q.start_block);
      default:                unit_x = cnt_q;
    endcase
  end

  fca_step_unit #(
    .CW(CW)
  ) u_step (
    .x_i    (unit_x),
    .lim_i  (lim),
    .inc_o  (unit_inc),
    .flags_o(fl)
  );

  // The scan reads at its index; chain walks read at the current block.
  assign mem_raddr = (state_q == ST_SCAN_RD) ? cnt_q[AW-1:0] : blk_q[AW-1:0];

  fca_table_ram #(
    .DEPTH(TABLE_DEPTH),
    .AW   (AW),
    .EW   (EW)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    blk_d       = blk_q;
    bound_d     = bound_q;
    mark_d      = mark_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    mem_waddr   = cnt_q[AW-1:0];
    mem_wdata   = EW'(ENTRY_FREE);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          res_d   = '0;
          cnt_d   = '0;
          blk_d   = EW'(in_data_i.start_block);
          bound_d = 1'b0;
          case (in_data_i.mode)
            MODE_FORMAT: begin
              mark_d  = 1'b1;
              state_d = ST_SWEEP;
            end
            MODE_ALLOCATE: begin
              cnt_d   = meta_end;
              state_d = ST_SCAN_RD;
            end
            MODE_FREE: state_d = ST_FREE_RD;
            MODE_SEEK: state_d = ST_SEEK_RD;
            default:   state_d = ST_FINISH;
          endcase
        end
      end

      // Whole-table pass: clears after reset, clears and marks metadata on format.
      ST_SWEEP: begin
        mem_we = 1'b1;
        if (mark_q && (cnt_q < meta_end) && !fl.ge_lim) begin
          mem_wdata = EW'(ENTRY_END);
        end
        cnt_d = unit_inc;
        if (cnt_q == CW'(TABLE_DEPTH - 1)) begin
          mark_d  = 1'b0;
          state_d = mark_q ? ST_FINISH : ST_IDLE;
        end
      end

      ST_SCAN_RD: begin
        if (fl.ge_lim) begin
          res_d.status = STAT_NO_FREE;
          state_d      = ST_FINISH;
        end else begin
          state_d = ST_SCAN_CHK;
        end
      end

      ST_SCAN_CHK: begin
        if (mem_rdata == EW'(ENTRY_FREE)) begin
          mem_we             = 1'b1;
          mem_wdata          = EW'(ENTRY_END);
          res_d.result_block = BLOCK_W'(cnt_q);
          state_d            = req_q.link_after ? ST_LINK : ST_FINISH;
        end else begin
          cnt_d   = unit_inc;
          state_d = ST_SCAN_RD;
        end
      end

      // The link is dropped when the predecessor lies outside the range.
      ST_LINK: begin
        if (!fl.ge_lim) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(req_q.start_block);
          mem_wdata = EW'(cnt_q);
        end
        state_d = ST_FINISH;
      end

      ST_FREE_RD: begin
        if (fl.is_end) begin
          state_d = ST_FINISH;
        end else if (fl.ge_lim) begin
          res_d.status = STAT_CHAIN_END;
          state_d      = ST_FINISH;
        end else if (bound_q) begin
          res_d.status = STAT_BOUND;
          state_d      = ST_FINISH;
        end else begin
          state_d = ST_FREE_WR;
        end
      end

      ST_FREE_WR: begin
        mem_we            = 1'b1;
        mem_waddr         = blk_q[AW-1:0];
        mem_wdata         = EW'(ENTRY_FREE);
        blk_d             = mem_rdata;
        cnt_d             = unit_inc;
        bound_d           = fl.inc_ge_lim;
        res_d.freed_count = COUNT_W'(unit_inc);
        state_d           = ST_FREE_RD;
      end

      ST_SEEK_RD: begin
        if (cnt_q == CW'(req_q.walk_count)) begin
          res_d.result_block = BLOCK_W'(blk_q);
          state_d            = ST_FINISH;
        end else if (fl.is_end || fl.ge_lim) begin
          res_d.status       = STAT_CHAIN_END;
          res_d.result_block = ENTRY_END;
          state_d            = ST_FINISH;
        end else begin
          state_d = ST_SEEK_NX;
        end
      end

      ST_SEEK_NX: begin
        blk_d   = mem_rdata;
        cnt_d   = unit_inc;
        state_d = ST_SEEK_RD;
      end

      // Hand the result to the output register once it is free.
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      cnt_q       <= '0;
      bound_q     <= 1'b0;
      mark_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      bound_q     <= bound_d;
      mark_q      <= mark_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    req_q <= req_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A chain entry is only released when it lies inside the usable range.
  `FCA_ASSERT(a_release_in_range, clk_i, rst_ni, (state_q == ST_FREE_WR) |-> (CW'(blk_q) < lim))
  // The release count never runs past the range size.
  `FCA_ASSERT(a_release_bounded, clk_i, rst_ni, (state_q == ST_FREE_RD) |-> (cnt_q <= lim))
  // An accepted command always occupies the sequencer in the next cycle.
  `FCA_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o)
  // No command is taken while reset holds the table clearing pass, even before the
  // first edge has loaded the state register.
  `FCA_ASSERT_ALWAYS(a_no_accept_in_reset, clk_i, !rst_ni |-> (in_ready_o !== 1'b1))

endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for fat_chain_allocator (format, allocate, free chain, seek).
// Depends on fca_pkg and the RTL only. Results are checked against an in-bench mirror of the
// allocation table, under several register settings and several idling patterns.
module testbench import fca_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = FCA_TABLE_DEPTH;
  localparam int unsigned SETTLE      = 16;     // idle cycles after the last result of a phase
  localparam int unsigned STALL_LIMIT = 40000;  // cycles without any beat before giving up
  localparam int unsigned HOLD_CYCLES = 300;    // long receiver hold-off
  localparam int unsigned RECENT_MAX  = 48;
  localparam int          NUM_PROBES  = 31;
  localparam int          NUM_PHASES  = 9;
  localparam int          HOLD_PHASE  = 6;
  localparam int          PAUSE_PHASE = 2;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_e;

  typedef struct {
    bit          is_cfg;
    logic        reg_idx;
    int unsigned reg_val;
    fca_in_t     cmd;
    bit          pinned;
    fca_out_t    want;
  } probe_row_t;

  typedef struct {
    int unsigned total;
    int unsigned tblk;
    idling_e     idling;
    int unsigned items;
    bit          fresh;
  } phase_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic                  cfg_idx   = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  fca_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  fca_out_t              out_data;

  // Mirror of the table and of the two registers.
  logic [BLOCK_W-1:0] fat_mirror [DEPTH] = '{default: ENTRY_FREE};
  int unsigned total_cfg = TOTAL_RESET;
  int unsigned tblk_cfg  = TBLK_RESET;

  fca_out_t           pending_replies [$];
  logic [BLOCK_W-1:0] recent_blocks [$];

  bit          pin_on    = 1'b0;
  fca_out_t    pin_want  = '0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  bit          hold_req  = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  int unsigned error_count = 0;
  int unsigned reg_writes  = 0;
  int unsigned mode_hits   [4] = '{default: 0};
  int unsigned status_hits [4] = '{default: 0};

  probe_row_t probe_rows [NUM_PROBES];
  phase_t     plan [NUM_PHASES];

  fat_chain_allocator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #2ns clk = 1'b1;
    #2ns clk = 1'b0;
  end

  // Applies one command to the mirror and returns the result beat it should produce.
  function automatic fca_out_t fat_apply(input fca_in_t c);
    fca_out_t           r;
    int unsigned        lim;
    int unsigned        blk;
    int unsigned        idx;
    int unsigned        freed;
    logic [BLOCK_W-1:0] nxt;
    r   = '0;
    lim = (total_cfg < DEPTH) ? total_cfg : DEPTH;
    case (c.mode)
      MODE_FORMAT: begin
        foreach (fat_mirror[i]) fat_mirror[i] = ENTRY_FREE;
        for (idx = 0; idx < tblk_cfg + META_FIXED && idx < lim; idx++) begin
          fat_mirror[idx] = ENTRY_END;
        end
      end
      MODE_ALLOCATE: begin
        idx = tblk_cfg + META_FIXED;
        while (idx < lim && fat_mirror[idx] != ENTRY_FREE) idx++;
        if (idx >= lim) begin
          r.status = STAT_NO_FREE;
        end else begin
          fat_mirror[idx] = ENTRY_END;
          // A predecessor outside the used range gets no link, but the block is still taken.
          if (c.link_after && c.start_block < lim) fat_mirror[c.start_block] = BLOCK_W'(idx);
          r.result_block = BLOCK_W'(idx);
        end
      end
      MODE_FREE: begin
        blk   = c.start_block;
        freed = 0;
        while (blk != ENTRY_END) begin
          if (blk >= lim) begin
            r.status = STAT_CHAIN_END;
            break;
          end
          // Every visit counts, so a loop runs into the bound after lim releases.
          if (freed >= lim) begin
            r.status = STAT_BOUND;
            break;
          end
          nxt = fat_mirror[blk];
          fat_mirror[blk] = ENTRY_FREE;
          freed++;
          blk = nxt;
        end
        r.freed_count = COUNT_W'(freed);
      end
      MODE_SEEK: begin
        blk = c.start_block;
        for (idx = 0; idx < c.walk_count; idx++) begin
          if (blk == ENTRY_END || blk >= lim) begin
            r.status = STAT_CHAIN_END;
            blk      = ENTRY_END;
            break;
          end
          blk = fat_mirror[blk];
        end
        r.result_block = BLOCK_W'(blk);
      end
    endcase
    return r;
  endfunction

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("mismatch %0d at %0t: %s", error_count, $time, msg);
  endfunction

  // Mostly blocks of live chains; the rest lands in or just past the used range, or anywhere.
  function automatic logic [BLOCK_W-1:0] pick_block();
    int unsigned r;
    int unsigned lim;
    r   = $urandom_range(0, 99);
    lim = (total_cfg < DEPTH) ? total_cfg : DEPTH;
    if (recent_blocks.size() != 0 && r < 70) begin
      return recent_blocks[$urandom_range(0, recent_blocks.size() - 1)];
    end
    if (r < 85) return BLOCK_W'($urandom_range(0, lim + 1));
    return BLOCK_W'($urandom_range(0, DEPTH - 1));
  endfunction

  function automatic probe_row_t op_row(input logic [1:0] mode, input int unsigned start,
                                        input bit link, input int unsigned count);
    probe_row_t r;
    r.is_cfg            = 1'b0;
    r.reg_idx           = 1'b0;
    r.reg_val           = 0;
    r.cmd.mode          = mode;
    r.cmd.start_block   = BLOCK_W'(start);
    r.cmd.link_after    = link;
    r.cmd.walk_count    = BLOCK_W'(count);
    r.pinned            = 1'b0;
    r.want              = '0;
    return r;
  endfunction

  function automatic probe_row_t pin(input probe_row_t r, input logic [1:0] status,
                                     input int unsigned block, input int unsigned freed);
    r.pinned            = 1'b1;
    r.want.status       = status;
    r.want.result_block = BLOCK_W'(block);
    r.want.freed_count  = COUNT_W'(freed);
    return r;
  endfunction

  function automatic probe_row_t reg_row(input logic idx, input int unsigned value);
    probe_row_t r;
    r         = op_row(MODE_FORMAT, 0, 1'b0, 0);
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = value;
    return r;
  endfunction

  // Offers one command beat after a random gap and returns at the edge that takes it.
  task automatic send_cmd(input fca_in_t c, input bit pinned, input fca_out_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    pin_on   = pinned;
    pin_want = want;
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops offering commands and waits until every pending result has come back.
  task automatic drain(input int unsigned settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    if (idx == CFG_TOTAL_BLOCKS) total_cfg = value & 32'h1FFF;
    else tblk_cfg = value & 32'h7F;
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stalls, or a long hold-off when the stimulus asks for one.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Checks result beats against the oldest prediction, then predicts accepted commands.
  always @(posedge clk) begin : port_watch
    fca_out_t want;
    fca_out_t seen;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen = out_data;
        if (pending_replies.size() == 0) begin
          note_error($sformatf("unexpected result: status %0d block %0d freed %0d",
                               seen.status, seen.result_block, seen.freed_count));
        end else begin
          want = pending_replies.pop_front();
          status_hits[want.status]++;
          if (seen.status !== want.status)
            note_error($sformatf("status: expected %0d, got %0d", want.status, seen.status));
          if (seen.result_block !== want.result_block)
            note_error($sformatf("result_block: expected %0d, got %0d",
                                 want.result_block, seen.result_block));
          if (seen.freed_count !== want.freed_count)
            note_error($sformatf("freed_count: expected %0d, got %0d",
                                 want.freed_count, seen.freed_count));
        end
      end
      if (in_valid && in_ready) begin
        want = fat_apply(in_data);
        mode_hits[in_data.mode]++;
        if (in_data.mode == MODE_FORMAT) begin
          recent_blocks.delete();
        end else if (in_data.mode == MODE_ALLOCATE && want.status == STAT_OK) begin
          recent_blocks.push_back(want.result_block);
          if (recent_blocks.size() > RECENT_MAX) void'(recent_blocks.pop_front());
        end
        pending_replies.push_back(pin_on ? pin_want : want);
      end
    end
  end

  // Watchdog: any beat, or a register write, restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    fca_in_t     cmd;
    int unsigned roll;
    int unsigned sub;
    int unsigned n;

    // Directed commands, starting from the reset register values (4096 blocks, 4 table
    // blocks) and an all-free table.
    probe_rows = '{
      pin(op_row(MODE_SEEK, 0, 1'b0, 0), STAT_OK, 0, 0),            // zero walk count
      pin(op_row(MODE_SEEK, 4095, 1'b1, 4095), STAT_OK, 0, 0),      // longest walk, free table
      pin(op_row(MODE_FREE, 1, 1'b0, 0), STAT_OK, 0, 0),            // chain that is only its end
      pin(op_row(MODE_FREE, 5, 1'b0, 0), STAT_BOUND, 0, 4096),      // loops through block 0
      pin(op_row(MODE_ALLOCATE, 0, 1'b0, 0), STAT_OK, 6, 0),
      pin(op_row(MODE_FORMAT, 4095, 1'b1, 4095), STAT_OK, 0, 0),
      pin(op_row(MODE_ALLOCATE, 0, 1'b0, 0), STAT_OK, 6, 0),
      pin(op_row(MODE_ALLOCATE, 6, 1'b1, 0), STAT_OK, 7, 0),
      op_row(MODE_ALLOCATE, 7, 1'b1, 0),
      op_row(MODE_SEEK, 6, 1'b0, 2),
      op_row(MODE_SEEK, 6, 1'b0, 3),
      pin(op_row(MODE_SEEK, 6, 1'b0, 4), STAT_CHAIN_END, 1, 0),     // walks past the end
      op_row(MODE_ALLOCATE, 4095, 1'b1, 0),
      pin(op_row(MODE_FREE, 6, 1'b0, 0), STAT_OK, 0, 3),
      op_row(MODE_ALLOCATE, 6, 1'b1, 0),                            // links a block to itself
      reg_row(CFG_TOTAL_BLOCKS, 3),
      reg_row(CFG_TABLE_BLOCKS, 1),
      pin(op_row(MODE_FORMAT, 0, 1'b0, 0), STAT_OK, 0, 0),
      pin(op_row(MODE_ALLOCATE, 0, 1'b0, 0), STAT_NO_FREE, 0, 0),
      op_row(MODE_FREE, 2, 1'b0, 0),
      pin(op_row(MODE_FREE, 3, 1'b0, 0), STAT_CHAIN_END, 0, 0),     // start beyond the limit
      pin(op_row(MODE_SEEK, 5, 1'b0, 1), STAT_CHAIN_END, 1, 0),
      reg_row(CFG_TOTAL_BLOCKS, 50),                                // metadata past the limit
      reg_row(CFG_TABLE_BLOCKS, 64),
      pin(op_row(MODE_FORMAT, 0, 1'b0, 0), STAT_OK, 0, 0),
      pin(op_row(MODE_ALLOCATE, 0, 1'b0, 0), STAT_NO_FREE, 0, 0),
      reg_row(CFG_TOTAL_BLOCKS, 100),
      pin(op_row(MODE_FORMAT, 0, 1'b0, 0), STAT_OK, 0, 0),
      pin(op_row(MODE_ALLOCATE, 4000, 1'b1, 0), STAT_OK, 66, 0),   // predecessor out of range
      pin(op_row(MODE_SEEK, 4000, 1'b0, 1), STAT_CHAIN_END, 1, 0),
      op_row(MODE_FREE, 66, 1'b0, 0)
    };

    // Most phases use small tables so that format and long walks stay rare in cycles.
    plan = '{
      '{4096,  4, IDLE_NONE,     100, 1'b0},
      '{  16,  1, IDLE_SENDER,   110, 1'b1},
      '{  37,  9, IDLE_RECEIVER, 110, 1'b1},
      '{4096, 64, IDLE_BOTH,      90, 1'b1},
      '{   3, 64, IDLE_NONE,      40, 1'b0},
      '{ 200, 30, IDLE_SENDER,   110, 1'b1},
      '{  64,  2, IDLE_RECEIVER, 110, 1'b1},
      '{1000, 16, IDLE_BOTH,     100, 1'b0},
      '{  24,  5, IDLE_NONE,     155, 1'b1}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The first command waits out the clearing pass that follows reset.
    foreach (probe_rows[k]) begin
      if (probe_rows[k].is_cfg) begin
        drain(SETTLE);
        write_reg(probe_rows[k].reg_idx, probe_rows[k].reg_val);
      end else begin
        send_cmd(probe_rows[k].cmd, probe_rows[k].pinned, probe_rows[k].want);
      end
    end

    foreach (plan[p]) begin
      drain(SETTLE);
      write_reg(CFG_TOTAL_BLOCKS, plan[p].total);
      write_reg(CFG_TABLE_BLOCKS, plan[p].tblk);
      case (plan[p].idling)
        IDLE_NONE:     begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        IDLE_SENDER:   begin tx_idle_pct = 47; rx_stall_pct = 0;  end
        IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct = 47; end
        IDLE_BOTH:     begin tx_idle_pct = 9;  rx_stall_pct = 9;  end
      endcase
      for (n = 0; n < plan[p].items; n++) begin
        // Mid-phase pressure: a long receiver hold-off while commands keep coming, and
        // elsewhere a full pause until every result is back.
        if (n == plan[p].items / 2 && p == HOLD_PHASE) hold_req = 1'b1;
        if (n == plan[p].items / 2 && p == PAUSE_PHASE) drain(SETTLE);

        roll            = $urandom_range(0, 99);
        sub             = $urandom_range(0, 9);
        cmd.start_block = pick_block();
        cmd.link_after  = 1'($urandom_range(0, 1));
        cmd.walk_count  = BLOCK_W'($urandom_range(0, DEPTH - 1));
        if (roll < 4 || (n == 0 && plan[p].fresh)) begin
          cmd.mode = MODE_FORMAT;
        end else if (roll < 44) begin
          // Growing a chain from its newest block is the common case.
          cmd.mode       = MODE_ALLOCATE;
          cmd.link_after = (sub < 7);
          if (recent_blocks.size() != 0 && $urandom_range(0, 99) < 55)
            cmd.start_block = recent_blocks[recent_blocks.size() - 1];
        end else if (roll < 66) begin
          cmd.mode = MODE_FREE;
          if (sub == 0) cmd.start_block = ENTRY_END;
        end else begin
          cmd.mode = MODE_SEEK;
          if (sub == 0) cmd.walk_count = '0;
          else if (sub < 9) cmd.walk_count = BLOCK_W'($urandom_range(1, 12));
        end
        send_cmd(cmd, 1'b0, '0);
      end
    end

    drain(SETTLE);
    if (pending_replies.size() != 0)
      note_error($sformatf("%0d results never arrived", pending_replies.size()));

    $display("summary: %0d register writes; commands format %0d, allocate %0d, free %0d, seek %0d",
             reg_writes, mode_hits[MODE_FORMAT], mode_hits[MODE_ALLOCATE],
             mode_hits[MODE_FREE], mode_hits[MODE_SEEK]);
    $display("summary: results ok %0d, no free %0d, chain end %0d, bound %0d; mismatches %0d",
             status_hits[STAT_OK], status_hits[STAT_NO_FREE], status_hits[STAT_CHAIN_END],
             status_hits[STAT_BOUND], error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== fat_chain_allocator.f =====
+incdir+sv
sv/fca_pkg.sv
sv/fca_table_ram.sv
sv/fca_step_unit.sv
sv/fat_chain_allocator.sv
dv/testbench.sv
